@@ hdl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the I2C master transaction sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // Request and event codes carried in the kind field
    localparam logic [2:0] KIND_START_WR   = 3'd0;
    localparam logic [2:0] KIND_START_RD   = 3'd1;
    localparam logic [2:0] KIND_START_WRRD = 3'd2;
    localparam logic [2:0] KIND_WR_EVENT   = 3'd3;
    localparam logic [2:0] KIND_RD_EVENT   = 3'd4;

    // Commands to the byte-level bus engine
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_ADDR      = 3'd1;
    localparam logic [2:0] CMD_SEND      = 3'd2;
    localparam logic [2:0] CMD_STOP      = 3'd3;
    localparam logic [2:0] CMD_ACK_RECV  = 3'd4;
    localparam logic [2:0] CMD_NACK_STOP = 3'd5;

    // Completion status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NODEV = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Address byte direction handling
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hfe;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ADDR  = 4'b0010,
        PH_WDATA = 4'b0100,
        PH_RDATA = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  target_addr;
        logic [15:0] first_len;
        logic [15:0] second_len;
        logic        bus_idle;
        logic        rx_nack;
        logic        arb_lost;
        logic        bus_error;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  bus_cmd;
        logic [7:0]  addr_byte;
        logic [7:0]  data_byte;
        logic [15:0] buf_index;
        logic        store_valid;
        logic        finished;
        logic [1:0]  status;
    } t_out_item;

endpackage

`default_nettype wire

@@ hdl/i2c_master_transaction_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Runs write, read and write-then-read I2C transactions over a byte-level
// bus engine: one result word for each request or event word.
// ----------------------------------------------------------------------------
//
//   channel   signals                         direction  word
//   in        i_in_valid/o_in_ready/i_in_data   input      t_in_item
//   out       o_out_valid/i_out_ready/o_out_data output    t_out_item
//
// One word per cycle sustained while the out channel is not stalled; a word
// that is taken passes through the input register, the step logic and the
// result register.
// Transaction state is updated when a word moves from the input register
// into the result register.
// A stall on the out channel holds the result register; the input register
// still takes one word behind it.
// Reset clears both valid flags and returns the state to idle with zero counts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    logic      item_valid;
    t_in_item  item;
    logic      out_can_load;
    logic      advance;
    t_out_item result;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [LENGTH_BITS-1:0] r_wr_rem;
    logic [LENGTH_BITS-1:0] n_wr_rem;
    logic [LENGTH_BITS-1:0] r_rd_rem;
    logic [LENGTH_BITS-1:0] n_rd_rem;
    logic [LENGTH_BITS-1:0] r_wr_idx;
    logic [LENGTH_BITS-1:0] n_wr_idx;
    logic [LENGTH_BITS-1:0] r_rd_idx;
    logic [LENGTH_BITS-1:0] n_rd_idx;
    logic [7:0]             r_rd_addr;
    logic [7:0]             n_rd_addr;

    assign advance = item_valid && out_can_load;

    i2cms_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .i_consume (advance),
        .o_valid   (item_valid),
        .o_data    (item)
    );

    i2cms_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_item    (item),
        .i_phase   (r_phase),
        .i_wr_rem  (r_wr_rem),
        .i_rd_rem  (r_rd_rem),
        .i_wr_idx  (r_wr_idx),
        .i_rd_idx  (r_rd_idx),
        .i_rd_addr (r_rd_addr),
        .o_phase   (n_phase),
        .o_wr_rem  (n_wr_rem),
        .o_rd_rem  (n_rd_rem),
        .o_wr_idx  (n_wr_idx),
        .o_rd_idx  (n_rd_idx),
        .o_rd_addr (n_rd_addr),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_wr_rem  <= '0;
            r_rd_rem  <= '0;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_rd_addr <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_wr_rem  <= n_wr_rem;
            r_rd_rem  <= n_rd_rem;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_rd_addr <= n_rd_addr;
        end
    end

    i2cms_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_data     (result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire

@@ hdl/i2cms_in_stage.sv @@
// ----------------------------------------------------------------------------
// i2cms_in_stage
// Input register: captures one request or event word and holds it until
// the step logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_in_stage
    import i2cms_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    input  wire logic     i_consume,
    output logic          o_valid,
    output t_in_item      o_data
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_data;

    // Take a new word when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || i_consume;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_consume) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ hdl/i2cms_step.sv @@
// ----------------------------------------------------------------------------
// i2cms_step
// Transaction step logic: from one word and the current transaction state,
// forms the bus command, the result word and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_step
    import i2cms_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire t_in_item               i_item,
    input  wire t_phase                 i_phase,
    input  wire logic [LENGTH_BITS-1:0] i_wr_rem,
    input  wire logic [LENGTH_BITS-1:0] i_rd_rem,
    input  wire logic [LENGTH_BITS-1:0] i_wr_idx,
    input  wire logic [LENGTH_BITS-1:0] i_rd_idx,
    input  wire logic [7:0]             i_rd_addr,
    output t_phase                      o_phase,
    output logic [LENGTH_BITS-1:0]      o_wr_rem,
    output logic [LENGTH_BITS-1:0]      o_rd_rem,
    output logic [LENGTH_BITS-1:0]      o_wr_idx,
    output logic [LENGTH_BITS-1:0]      o_rd_idx,
    output logic [7:0]                  o_rd_addr,
    output t_out_item                   o_result
);

    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

    logic [LENGTH_BITS-1:0] len1;
    logic [LENGTH_BITS-1:0] len2;
    logic [7:0]             rd_addr_new;

    assign len1        = LENGTH_BITS'(i_item.first_len);
    assign len2        = LENGTH_BITS'(i_item.second_len);
    assign rd_addr_new = i_item.target_addr | ADDR_READ_BIT;

    always_comb begin
        o_phase   = i_phase;
        o_wr_rem  = i_wr_rem;
        o_rd_rem  = i_rd_rem;
        o_wr_idx  = i_wr_idx;
        o_rd_idx  = i_rd_idx;
        o_rd_addr = i_rd_addr;
        o_result  = '0;

        case (i_item.kind)
            KIND_START_WR, KIND_START_RD, KIND_START_WRRD: begin
                if (i_phase == PH_IDLE && i_item.bus_idle) begin
                    o_result.accepted = 1'b1;
                    o_result.bus_cmd  = CMD_ADDR;
                    o_wr_idx  = LEN_ZERO;
                    o_rd_idx  = LEN_ZERO;
                    o_rd_addr = rd_addr_new;
                    o_phase   = PH_ADDR;
                    if (i_item.kind == KIND_START_RD) begin
                        o_wr_rem = LEN_ZERO;
                        o_rd_rem = len1;
                        o_result.addr_byte = rd_addr_new;
                    end else begin
                        o_wr_rem = len1;
                        o_rd_rem = (i_item.kind == KIND_START_WRRD) ? len2 : LEN_ZERO;
                        o_result.addr_byte = i_item.target_addr & ADDR_WRITE_MASK;
                    end
                end
            end
            KIND_WR_EVENT: begin
                if (i_phase != PH_IDLE) begin
                    if (i_item.rx_nack && i_phase == PH_ADDR) begin
                        // nobody answered the address
                        o_phase           = PH_IDLE;
                        o_result.bus_cmd  = CMD_STOP;
                        o_result.finished = 1'b1;
                        o_result.status   = ST_NODEV;
                    end else if (i_item.arb_lost || i_item.bus_error) begin
                        // bus is not ours: end without a stop
                        o_phase           = PH_IDLE;
                        o_result.finished = 1'b1;
                        o_result.status   = ST_ERROR;
                    end else if (i_wr_rem != LEN_ZERO) begin
                        if (i_item.rx_nack) begin
                            o_phase           = PH_IDLE;
                            o_result.bus_cmd  = CMD_STOP;
                            o_result.finished = 1'b1;
                            o_result.status   = ST_ERROR;
                        end else begin
                            o_phase            = PH_WDATA;
                            o_result.bus_cmd   = CMD_SEND;
                            o_result.data_byte = i_item.tx_byte;
                            o_result.buf_index = 16'(i_wr_idx);
                            o_wr_idx = i_wr_idx + LEN_ONE;
                            o_wr_rem = i_wr_rem - LEN_ONE;
                        end
                    end else if (i_rd_rem != LEN_ZERO) begin
                        // turn round with a repeated start
                        o_phase            = PH_ADDR;
                        o_result.bus_cmd   = CMD_ADDR;
                        o_result.addr_byte = i_rd_addr;
                    end else begin
                        o_phase           = PH_IDLE;
                        o_result.bus_cmd  = CMD_STOP;
                        o_result.finished = 1'b1;
                        o_result.status   = ST_DONE;
                    end
                end
            end
            KIND_RD_EVENT: begin
                if (i_phase != PH_IDLE) begin
                    o_result.data_byte   = i_item.rx_byte;
                    o_result.buf_index   = 16'(i_rd_idx);
                    o_result.store_valid = 1'b1;
                    o_rd_idx = i_rd_idx + LEN_ONE;
                    // a zero count ends on this byte as well
                    if (i_rd_rem <= LEN_ONE) begin
                        o_rd_rem          = LEN_ZERO;
                        o_phase           = PH_IDLE;
                        o_result.bus_cmd  = CMD_NACK_STOP;
                        o_result.finished = 1'b1;
                        o_result.status   = ST_DONE;
                    end else begin
                        o_rd_rem         = i_rd_rem - LEN_ONE;
                        o_phase          = PH_RDATA;
                        o_result.bus_cmd = CMD_ACK_RECV;
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/i2cms_out_stage.sv @@
// ----------------------------------------------------------------------------
// i2cms_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_out_stage
    import i2cms_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_item i_data,
    output logic           o_can_load,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ hdl/i2cms_checker.sv @@
// ----------------------------------------------------------------------------
// i2cms_props
// Port-level checks for the I2C master transaction sequencer, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_props
    import i2cms_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A taken start always issues the address
    a_accept_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |-> o_out_data.bus_cmd == CMD_ADDR
        && !o_out_data.finished)
        else $error("accepted start without address command");

    // A stored byte comes with an ack or a nack-and-stop
    a_store_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.store_valid |->
        (o_out_data.bus_cmd == CMD_ACK_RECV && !o_out_data.finished) ||
        (o_out_data.bus_cmd == CMD_NACK_STOP && o_out_data.finished))
        else $error("stored byte with wrong bus command");

    // Status only means something on a finished transaction
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.finished |-> o_out_data.status == ST_DONE)
        else $error("status set on unfinished word");

endmodule

bind i2c_master_transaction_sequencer i2cms_props u_i2cms_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
